// File: rtl/msb_first_bit_field_reader_defines.svh
// ----------------------------------------------------------------------------
// MSB-first bit field reader assertion macros
// Shorthand for the concurrent checks on the reader's ports. Every macro
// samples on i_clk. The first two are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_FIELD_READER_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_READER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define MFBR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MFBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same as MFBR_ASSERT_NEXT, but also checked while reset is applied.
`define MFBR_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mfbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit field reader package
// Request codes, transfer types and sizing constants of the reader.
// ----------------------------------------------------------------------------
package mfbr_pkg;

    // Default size of the byte store, in bytes (a power of two).
    localparam int unsigned STORE_BYTES_DEF = 4096;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned AMOUNT_W   = 12;
    localparam int unsigned BANKS      = 8;
    localparam int unsigned BANK_SEL_W = 3;
    localparam int unsigned WIN_BYTES  = 5;
    localparam int unsigned WIN_W      = WIN_BYTES * BYTE_W;

    // Longest bit read and longest whole-byte read.
    localparam int unsigned MAX_BITS  = 32;
    localparam int unsigned MAX_BYTES = 4;

    typedef enum logic [2:0] {
        REQ_WRITE      = 3'd0,
        REQ_READ_BITS  = 3'd1,
        REQ_READ_BYTES = 3'd2,
        REQ_SKIP       = 3'd3,
        REQ_ALIGN      = 3'd4,
        REQ_SEEK       = 3'd5,
        REQ_CLEAR_TEMP = 3'd6,
        REQ_STATUS     = 3'd7
    } t_req_type;

    typedef struct packed {
        t_req_type             req_type;
        logic [POS_W-1:0]      address;
        logic [BYTE_W-1:0]     byte_data;
        logic [AMOUNT_W-1:0]   amount;
        logic                  sign_extend;
        logic                  big_endian;
        logic                  left_justify;
        logic                  consume;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  position;
        logic [2:0]        bits_left;
        logic [WORD_W-1:0] total_consumed;
        logic [WORD_W-1:0] temp_consumed;
    } t_out_item;

endpackage

// File: rtl/mfbr_byte_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit field reader byte store
// Eight interleaved single-port-read banks that return a five-byte window
// starting at any byte position, registered in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module mfbr_byte_store #(
    parameter int unsigned STORE_BYTES = mfbr_pkg::STORE_BYTES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [$clog2(STORE_BYTES)-1:0]         i_wr_addr,
    input  logic [mfbr_pkg::BYTE_W-1:0]            i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [$clog2(STORE_BYTES)-1:0]         i_rd_pos,
    output logic [mfbr_pkg::WIN_W-1:0]             o_window
);
    import mfbr_pkg::*;

    localparam int unsigned AW    = $clog2(STORE_BYTES);
    localparam int unsigned ROWS  = STORE_BYTES / BANKS;
    localparam int unsigned ROW_W = AW - BANK_SEL_W;
    localparam int unsigned ROW_BITS = BANKS * BYTE_W;

    logic [BYTE_W-1:0]     r_q [BANKS];
    logic [BANK_SEL_W-1:0] r_lo;
    logic [ROW_BITS-1:0]   w_row;
    logic [2*ROW_BITS-1:0] w_rot;

    // Bank b holds every byte whose address ends in b. A window of five
    // bytes touches five different banks, each at a row of its own.
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [BYTE_W-1:0]     r_mem [ROWS];
        logic [BANK_SEL_W-1:0] w_off;
        logic [AW-1:0]         w_addr;

        always_comb begin
            w_off  = BANK_SEL_W'(b) - i_rd_pos[BANK_SEL_W-1:0];
            w_addr = i_rd_pos + AW'(w_off);
        end

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_addr[BANK_SEL_W-1:0] == BANK_SEL_W'(b))) begin
                r_mem[i_wr_addr[AW-1:BANK_SEL_W]] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_q[b] <= r_mem[w_addr[AW-1:BANK_SEL_W]];
            end
        end

        assign w_row[ROW_BITS-1-b*BYTE_W -: BYTE_W] = r_q[b];
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_lo <= i_rd_pos[BANK_SEL_W-1:0];
        end
    end

    // Rotate the bank outputs so that the byte at the read position leads.
    always_comb begin
        w_rot    = {w_row, w_row} << ({r_lo, 3'b000});
        o_window = w_rot[2*ROW_BITS-1 -: WIN_W];
    end

endmodule

// File: rtl/msb_first_bit_field_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit field reader
// Reads bit fields and whole-byte fields MSB-first out of a loaded byte store.
// ----------------------------------------------------------------------------
// Every request returns exactly one result. In the cycle a request transfer
// completes, the byte store issues its read of the five bytes at the current
// position. Once the window is registered, the field is extracted; when the
// output register is free, the position, unread bit count and byte counts are
// written back and the result is loaded into the output register. The next
// request can transfer in the cycle after that: a new request is not taken
// before the one before it retires, as the store banks read through a register
// and each request needs the position that the one before it leaves. A
// result waiting on a stalled output does not hold up the next request's
// store read, but that request is not retired until the output register is
// free. Writes land in the store in the cycle their request transfers. The
// store is never cleared: reading a byte that was never written returns an
// undefined value, and there is no start-up sweep after reset. STORE_BYTES
// must be a power of two; positions and store addresses wrap at it, and the
// reported position carries the low twelve bits of the internal position.
// ----------------------------------------------------------------------------
module msb_first_bit_field_reader #(
    parameter int unsigned STORE_BYTES = mfbr_pkg::STORE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mfbr_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mfbr_pkg::t_out_item  o_out
);
    import mfbr_pkg::*;

    localparam int unsigned AW = $clog2(STORE_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    // Control state.
    t_state              r_state;
    logic [AW-1:0]       r_pos;
    logic [2:0]          r_ub;
    logic [WORD_W-1:0]   r_total;
    logic [WORD_W-1:0]   r_temp;
    logic                r_out_valid;

    // Payload state.
    t_in_item            r_req;
    t_out_item           r_out;

    logic                w_in_take;
    logic                w_out_free;
    logic                w_exec;
    logic [WIN_W-1:0]    w_window;

    // Bit read datapath.
    logic [5:0]          w_bit_n;
    logic [2:0]          w_skip;
    logic [WIN_W-1:0]    w_shl;
    logic [WORD_W-1:0]   w_bit_top;
    logic [5:0]          w_bit_sh;
    logic [WORD_W-1:0]   w_bit_val;
    logic [5:0]          w_bit_total;

    // Byte read datapath.
    logic [2:0]          w_byte_n;
    logic                w_byte_off;
    logic [WORD_W-1:0]   w_be;
    logic [WORD_W-1:0]   w_le;
    logic [WORD_W-1:0]   w_lj;
    logic [4:0]          w_byte_sh;
    logic [WORD_W-1:0]   w_byte_val;

    // Next state.
    logic [AMOUNT_W-1:0] w_adv;
    logic                w_seek;
    logic                w_clear;
    logic [WORD_W-1:0]   w_value;
    logic [2:0]          n_ub;
    logic [AW-1:0]       n_pos;
    logic [WORD_W-1:0]   n_total;
    logic [WORD_W-1:0]   n_temp;

    // One request is in flight at a time; it retires once the output
    // register is empty or being emptied in the same cycle.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_in_take  = i_in_valid && (r_state == ST_IDLE);
        w_out_free = !r_out_valid || !i_out_stall;
        w_exec     = (r_state == ST_EXEC) && w_out_free;
    end

    mfbr_byte_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_take && (i_in.req_type == REQ_WRITE)),
        .i_wr_addr (AW'(i_in.address)),
        .i_wr_data (i_in.byte_data),
        .i_rd_en   (w_in_take),
        .i_rd_pos  (r_pos),
        .o_window  (w_window)
    );

    // Bit read. The unread low bits of the current byte are what is left
    // after skipping its already used high bits. The field is taken from the
    // top of the window shifted past those used bits; an arithmetic shift
    // supplies the sign extension.
    always_comb begin
        w_bit_n   = (r_req.amount > AMOUNT_W'(MAX_BITS)) ? 6'(MAX_BITS)
                                                         : r_req.amount[5:0];
        w_skip    = 3'd0 - r_ub;
        w_shl     = w_window << w_skip;
        w_bit_top = w_shl[WIN_W-1 -: WORD_W];
        w_bit_sh  = 6'(MAX_BITS) - w_bit_n;
        if (r_req.sign_extend && (w_bit_n > 6'd1)) begin
            w_bit_val = WORD_W'($signed(w_bit_top) >>> w_bit_sh);
        end else begin
            w_bit_val = w_bit_top >> w_bit_sh;
        end
        // Whole bytes passed over are consumed; the remainder of the last
        // touched byte becomes the new unread bit count.
        w_bit_total = 6'(w_skip) + w_bit_n;
    end

    // Byte read. A consuming read in mid-byte first steps to the next byte.
    // The selected bytes are lined up most significant first for the
    // big-endian form, and reversed and left-justified for the others.
    always_comb begin
        w_byte_n   = (r_req.amount > AMOUNT_W'(MAX_BYTES)) ? 3'(MAX_BYTES)
                                                           : r_req.amount[2:0];
        w_byte_off = r_req.consume && (r_ub != 3'd0);
        w_be       = w_byte_off ? w_window[WORD_W-1:0] : w_window[WIN_W-1 -: WORD_W];
        w_le       = {w_be[7:0], w_be[15:8], w_be[23:16], w_be[31:24]};
        w_byte_sh  = {2'(3'(MAX_BYTES) - w_byte_n), 3'b000};
        w_lj       = w_le << w_byte_sh;
        if (r_req.big_endian) begin
            if (r_req.sign_extend) begin
                w_byte_val = WORD_W'($signed(w_be) >>> w_byte_sh);
            end else begin
                w_byte_val = w_be >> w_byte_sh;
            end
        end else if (r_req.left_justify) begin
            w_byte_val = w_lj;
        end else if (r_req.sign_extend) begin
            w_byte_val = WORD_W'($signed(w_lj) >>> w_byte_sh);
        end else begin
            w_byte_val = w_lj >> w_byte_sh;
        end
    end

    // Request decode: how far the position moves and what else changes.
    always_comb begin
        w_adv   = '0;
        w_seek  = 1'b0;
        w_clear = 1'b0;
        w_value = '0;
        n_ub    = r_ub;
        unique case (r_req.req_type)
            REQ_READ_BITS: begin
                if (w_bit_n != 6'd0) begin
                    w_value = w_bit_val;
                    w_adv   = AMOUNT_W'(w_bit_total[5:3]);
                    n_ub    = 3'd0 - w_bit_total[2:0];
                end
            end
            REQ_READ_BYTES: begin
                if (w_byte_n != 3'd0) begin
                    w_value = w_byte_val;
                    if (r_req.consume) begin
                        w_adv = AMOUNT_W'(w_byte_n) + AMOUNT_W'(w_byte_off);
                        n_ub  = 3'd0;
                    end
                end
            end
            REQ_SKIP: begin
                if (r_req.amount != '0) begin
                    w_adv = r_req.amount;
                    n_ub  = 3'd0;
                end
            end
            REQ_ALIGN: begin
                if (r_ub != 3'd0) begin
                    w_adv = AMOUNT_W'(1);
                    n_ub  = 3'd0;
                end
            end
            REQ_SEEK: begin
                w_seek = 1'b1;
                n_ub   = 3'd0;
            end
            REQ_CLEAR_TEMP: begin
                w_clear = 1'b1;
            end
            REQ_WRITE, REQ_STATUS: begin
            end
            default: begin
            end
        endcase

        n_pos   = w_seek ? AW'(r_req.address) : r_pos + AW'(w_adv);
        n_total = r_total + WORD_W'(w_adv);
        n_temp  = w_clear ? '0 : r_temp + WORD_W'(w_adv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_ub        <= 3'd0;
            r_total     <= '0;
            r_temp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_take) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_exec) begin
                        r_state <= ST_IDLE;
                        r_pos   <= n_pos;
                        r_ub    <= n_ub;
                        r_total <= n_total;
                        r_temp  <= n_temp;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_req <= i_in;
        end
        if (w_exec) begin
            r_out.value          <= w_value;
            r_out.position       <= POS_W'(n_pos);
            r_out.bits_left      <= n_ub;
            r_out.total_consumed <= n_total;
            r_out.temp_consumed  <= n_temp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/mfbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSB-first bit field reader checker
// Port-level checks of the reader's transfer behavior, bound to the top level.
// ----------------------------------------------------------------------------
`include "msb_first_bit_field_reader_defines.svh"

module mfbr_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  mfbr_pkg::t_in_item   i_in,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  mfbr_pkg::t_out_item  o_out
);
    import mfbr_pkg::*;

    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && !o_in_stall;

    // A stalled result stays offered and unchanged.
    `MFBR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result changed or dropped")

    // Only one request is worked on at a time.
    `MFBR_ASSERT_NEXT(a_one_in_flight, w_in_xfer, o_in_stall, "request taken while another is in progress")

    // After a request transfers, a result is on offer once its store read and execute state are done.
    `MFBR_ASSERT_SAME(a_result_due, w_in_xfer, ##2 o_out_valid, "no result two cycles after a request")

    // Reset leaves no result on offer.
    `MFBR_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid, "result offered after reset")

endmodule

bind msb_first_bit_field_reader mfbr_checker u_mfbr_checker (.*);
